// ===== rtl/mtcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mtcs_pkg;

    // Shared divider operand widths
    localparam int DVD_W  = 37;   // widest dividend: elements * parallel level + max chunks
    localparam int DVS_W  = 14;   // widest divisor: line bytes * parallel level
    localparam int BITS_W = 6;    // quotient bit count, up to DVD_W

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_BYTES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNKS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES     = 3'd4;
    localparam int CFG_DATA_W = 25;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
        logic [BITS_W-1:0] bits;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== rtl/mtcs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// Result valid in the cycle o_rsp.done is high.
module mtcs_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  mtcs_pkg::t_div_req  i_req,
    output mtcs_pkg::t_div_rsp  o_rsp
);
    import mtcs_pkg::*;

    logic [BITS_W-1:0] r_cnt;
    logic              r_done;
    logic [DVD_W-1:0]  r_q;
    logic [DVS_W-1:0]  r_acc;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W+1:0]  w_diff;

    assign w_diff = {1'b0, r_acc, r_q[DVD_W-1]} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == BITS_W'(1));
            if (i_req.start) begin
                r_cnt <= i_req.bits;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - BITS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            // left-align the dividend so only 'bits' steps are needed
            r_q   <= i_req.dividend << (BITS_W'(DVD_W) - i_req.bits);
            r_acc <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_cnt != '0) begin
            if (!w_diff[DVS_W+1]) begin
                r_acc <= w_diff[DVS_W-1:0];
                r_q   <= {r_q[DVD_W-2:0], 1'b1};
            end else begin
                r_acc <= {r_acc[DVS_W-2:0], r_q[DVD_W-1]};
                r_q   <= {r_q[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_acc;

endmodule

`default_nettype wire

// ===== rtl/memset_transfer_chunk_splitter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Memset transfer chunk splitter. A request is taken when start is high and busy is low;
// it gives the region size in bytes, and the block answers with a list of (base_offset,
// chunk_size) pairs in elements that cover the region in order, the final one with o_last.
// Each result is shown for exactly one cycle with o_valid high; the receiver cannot stall
// the block, so it must take every transfer as it comes. An empty request gives one
// result of size zero. busy stays high from the request until its last result has been
// issued, and a new request may be given in the cycle that result is on the ports.
// Setup runs its divisions in turn on a single shared one-bit-per-cycle divider, with an
// extra division when the chunk size has to grow to respect max_chunks, then gives one
// result per cycle (at most MAX_RESULTS). Configuration writes are always accepted
// (o_cfg_ready is tied high) and must only be made while busy is low; unused indexes
// are ignored.
module memset_transfer_chunk_splitter #(
    parameter int MAX_RESULTS = 64
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // request
    input  wire                              start,
    output logic                             busy,
    input  wire  [31:0]                      i_total_bytes,
    // results
    output logic                             o_valid,
    output logic [31:0]                      o_base_offset,
    output logic [31:0]                      o_chunk_size,
    output logic                             o_last,
    // configuration
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [mtcs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [mtcs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mtcs_pkg::*;

    localparam int NW = $clog2(MAX_RESULTS);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_NE    = 4'd1;  // total / element bytes
    localparam logic [3:0] S_LE    = 4'd2;  // line / element bytes
    localparam logic [3:0] S_MAIN  = 4'd3;  // elements mod group
    localparam logic [3:0] S_ROI   = 4'd4;  // initial chunk size
    localparam logic [3:0] S_THR   = 4'd5;  // threshold product
    localparam logic [3:0] S_CMP   = 4'd6;  // too many chunks?
    localparam logic [3:0] S_GROW  = 4'd7;  // grown chunk size
    localparam logic [3:0] S_ALIGN = 4'd8;  // round up to alignment
    localparam logic [3:0] S_RL    = 4'd9;  // remainder split
    localparam logic [3:0] S_EMIT  = 4'd10; // one result per cycle

    // configuration registers
    logic [3:0]  r_element_bytes;
    logic [24:0] r_chunk_bytes;
    logic [4:0]  r_parallel_level;
    logic [5:0]  r_max_chunks;
    logic [8:0]  r_line_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_element_bytes  <= 4'd4;
            r_chunk_bytes    <= 25'd65536;
            r_parallel_level <= 5'd1;
            r_max_chunks     <= 6'd32;
            r_line_bytes     <= 9'd128;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ELEMENT_BYTES:  r_element_bytes  <= i_cfg_data[3:0];
                CFG_CHUNK_BYTES:    r_chunk_bytes    <= i_cfg_data[24:0];
                CFG_PARALLEL_LEVEL: r_parallel_level <= i_cfg_data[4:0];
                CFG_MAX_CHUNKS:     r_max_chunks     <= i_cfg_data[5:0];
                CFG_LINE_BYTES:     r_line_bytes     <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // zero element bytes, parallel level, max chunks and line bytes read as one
    logic [3:0] w_eb;
    logic [4:0] w_pl;
    logic [5:0] w_mc;
    logic [8:0] w_line;

    assign w_eb   = (r_element_bytes  == '0) ? 4'd1 : r_element_bytes;
    assign w_pl   = (r_parallel_level == '0) ? 5'd1 : r_parallel_level;
    assign w_mc   = (r_max_chunks     == '0) ? 6'd1 : r_max_chunks;
    assign w_line = (r_line_bytes     == '0) ? 9'd1 : r_line_bytes;

    // shared divider
    t_div_req w_req;
    t_div_rsp w_rsp;

    mtcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // working registers
    logic [3:0]    r_state,     n_state;
    logic [31:0]   r_num,       n_num;       // elements in the request
    logic [8:0]    r_le,        n_le;        // line elements
    logic [13:0]   r_align,     n_align;     // line bytes * parallel level
    logic [13:0]   r_rem,       n_rem;       // elements past the main part
    logic [31:0]   r_main,      n_main;      // elements in the main part
    logic [37:0]   r_roi,       n_roi;       // main chunk size
    logic [36:0]   r_thr,       n_thr;
    logic [8:0]    r_tail,      n_tail;
    logic [13:0]   r_rl,        n_rl;
    logic          r_rl_pend,   n_rl_pend;
    logic          r_tail_pend, n_tail_pend;
    logic [38:0]   r_pos,       n_pos;
    logic [NW-1:0] r_n,         n_n;
    logic          r_o_valid,   n_o_valid;
    logic [31:0]   r_o_base,    n_o_base;
    logic [31:0]   r_o_size,    n_o_size;
    logic          r_o_last,    n_o_last;

    // emit-path helpers
    logic [31:0] w_left;
    logic [38:0] w_pos_next;
    logic        w_main_act;
    logic        w_more_main;
    logic        w_more;
    logic [8:0]  w_le_q;

    assign w_left      = r_main - r_pos[31:0];
    assign w_pos_next  = r_pos + 39'(r_roi);
    assign w_main_act  = r_pos < 39'(r_main);
    assign w_more_main = w_pos_next < 39'(r_main);
    assign w_le_q      = (w_rsp.quot[8:0] == '0) ? 9'd1 : w_rsp.quot[8:0];

    always_comb begin
        n_state     = r_state;
        n_num       = r_num;
        n_le        = r_le;
        n_align     = r_align;
        n_rem       = r_rem;
        n_main      = r_main;
        n_roi       = r_roi;
        n_thr       = r_thr;
        n_tail      = r_tail;
        n_rl        = r_rl;
        n_rl_pend   = r_rl_pend;
        n_tail_pend = r_tail_pend;
        n_pos       = r_pos;
        n_n         = r_n;
        n_o_valid   = 1'b0;
        n_o_base    = r_o_base;
        n_o_size    = r_o_size;
        n_o_last    = r_o_last;
        w_more      = 1'b0;
        w_req       = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_align        = 14'(w_line) * 14'(w_pl);
                    w_req.start    = 1'b1;
                    w_req.dividend = 37'(i_total_bytes);
                    w_req.divisor  = 14'(w_eb);
                    w_req.bits     = BITS_W'(32);
                    n_state        = S_NE;
                end
            end
            S_NE: begin
                if (w_rsp.done) begin
                    n_num          = w_rsp.quot[31:0];
                    w_req.start    = 1'b1;
                    w_req.dividend = 37'(w_line);
                    w_req.divisor  = 14'(w_eb);
                    w_req.bits     = BITS_W'(9);
                    n_state        = S_LE;
                end
            end
            S_LE: begin
                if (w_rsp.done) begin
                    n_le           = w_le_q;
                    w_req.start    = 1'b1;
                    w_req.dividend = 37'(r_num);
                    w_req.divisor  = 14'(w_le_q) * 14'(w_pl);
                    w_req.bits     = BITS_W'(32);
                    n_state        = S_MAIN;
                end
            end
            S_MAIN: begin
                if (w_rsp.done) begin
                    n_rem          = w_rsp.rem;
                    n_main         = r_num - 32'(w_rsp.rem);
                    w_req.start    = 1'b1;
                    w_req.dividend = 37'(30'(r_chunk_bytes) * 30'(w_pl));
                    w_req.divisor  = 14'(w_eb);
                    w_req.bits     = BITS_W'(30);
                    n_state        = S_ROI;
                end
            end
            S_ROI: begin
                if (w_rsp.done) begin
                    n_roi   = (w_rsp.quot[29:0] == '0) ? 38'd1 : 38'(w_rsp.quot[29:0]);
                    n_state = S_THR;
                end
            end
            S_THR: begin
                // num / roi > mc  <=>  num >= (mc + 1) * roi
                n_thr   = (37'(w_mc) + 37'd1) * 37'(r_roi[29:0]);
                n_state = S_CMP;
            end
            S_CMP: begin
                w_req.start = 1'b1;
                w_req.bits  = BITS_W'(DVD_W);
                if (37'(r_num) >= r_thr) begin
                    w_req.dividend = 37'(r_num) * 37'(w_pl) + 37'(w_mc) - 37'd1;
                    w_req.divisor  = 14'(w_mc);
                    n_state        = S_GROW;
                end else begin
                    w_req.dividend = r_roi[36:0];
                    w_req.divisor  = r_align;
                    n_state        = S_ALIGN;
                end
            end
            S_GROW: begin
                if (w_rsp.done) begin
                    n_roi          = 38'(w_rsp.quot);
                    w_req.start    = 1'b1;
                    w_req.dividend = w_rsp.quot;
                    w_req.divisor  = r_align;
                    w_req.bits     = BITS_W'(DVD_W);
                    n_state        = S_ALIGN;
                end
            end
            S_ALIGN: begin
                if (w_rsp.done) begin
                    if (w_rsp.rem != '0) begin
                        n_roi = r_roi - 38'(w_rsp.rem) + 38'(r_align);
                    end
                    w_req.start    = 1'b1;
                    w_req.dividend = 37'(r_rem);
                    w_req.divisor  = 14'(r_le);
                    w_req.bits     = BITS_W'(14);
                    n_state        = S_RL;
                end
            end
            S_RL: begin
                if (w_rsp.done) begin
                    n_tail      = w_rsp.rem[8:0];
                    n_rl        = r_rem - w_rsp.rem;
                    n_rl_pend   = (r_rem != w_rsp.rem);
                    n_tail_pend = (w_rsp.rem != '0);
                    n_pos       = '0;
                    n_n         = '0;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                n_o_valid = 1'b1;
                n_n       = r_n + NW'(1);
                if (w_main_act) begin
                    n_o_base = r_pos[31:0];
                    n_o_size = (r_roi < 38'(w_left)) ? r_roi[31:0] : w_left;
                    n_pos    = w_pos_next;
                    w_more   = w_more_main || r_rl_pend || r_tail_pend;
                end else if (r_rl_pend) begin
                    n_o_base  = r_main;
                    n_o_size  = 32'(r_rl);
                    n_rl_pend = 1'b0;
                    w_more    = r_tail_pend;
                end else if (r_tail_pend) begin
                    n_o_base    = r_main + 32'(r_rl);
                    n_o_size    = 32'(r_tail);
                    n_tail_pend = 1'b0;
                    w_more      = 1'b0;
                end else begin
                    // empty request
                    n_o_base = '0;
                    n_o_size = '0;
                    w_more   = 1'b0;
                end
                n_o_last = !w_more || (r_n == NW'(MAX_RESULTS - 1));
                if (n_o_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num       <= n_num;
        r_le        <= n_le;
        r_align     <= n_align;
        r_rem       <= n_rem;
        r_main      <= n_main;
        r_roi       <= n_roi;
        r_thr       <= n_thr;
        r_tail      <= n_tail;
        r_rl        <= n_rl;
        r_rl_pend   <= n_rl_pend;
        r_tail_pend <= n_tail_pend;
        r_pos       <= n_pos;
        r_n         <= n_n;
        r_o_base    <= n_o_base;
        r_o_size    <= n_o_size;
        r_o_last    <= n_o_last;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_base_offset = r_o_base;
    assign o_chunk_size  = r_o_size;
    assign o_last        = r_o_last;

endmodule

`default_nettype wire
